// ----- hdl/lprl_pkg.sv -----
`default_nettype none

package lprl_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int CMDQ_DEPTH    = 2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic        action;
    logic [6:0]  entry_index;
    logic [31:0] entry_prefix;
    logic [31:0] entry_mask;
    logic [7:0]  entry_port;
    logic [31:0] dest_addr;
  } in_item_t;

  typedef struct packed {
    logic       route_found;
    logic [7:0] out_port;
    logic [6:0] match_slot;
  } out_item_t;

  typedef enum logic {
    CMD_WRITE,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [6:0]  index;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [7:0]  port;
    logic [31:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [7:0]  port;
  } route_entry_t;

endpackage

`default_nettype wire

// ----- hdl/longest_prefix_route_lookup_top.sv -----
// Lookup: the back end scans n = min(entries_in_use, TABLE_DEPTH) entries, one per cycle,
//   keeps the best match and loads the result into the output register; n = 0 skips the scan.
//   The back end takes its next command only once that result is loaded.
// Table write: done by the idle back end, with no result; input queue holds two items ahead.
// Reset (rst_n low, synchronous): clears queues, scan control, result slot, entries_in_use.
// Route table contents are not cleared; a slot holds no defined entry until it is written.
`default_nettype none

module longest_prefix_route_lookup_top
  import lprl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input item channel
  input  wire logic       in_push,
  output logic            in_full,
  input  wire in_item_t   in_item,
  // result item channel
  output logic            out_empty,
  input  wire logic       out_pop,
  output out_item_t       out_item,
  // entries_in_use register write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  // command handoff from the front queue to the scan engine
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Front: accept items, classify write or lookup, drop writes past the
  // table, and hold them in a short queue so input can run up to two items
  // ahead of a scan.
  lprl_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: write the route table, or scan it one entry per cycle keeping the
  // matching entry with the largest mask value (earliest slot on a tie), then
  // hold the result in an output register until it is popped.
  lprl_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hdl/lprl_ram.sv -----
`default_nettype none

module lprl_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/lprl_front.sv -----
`default_nettype none

module lprl_front
  import lprl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic accept;
  logic keep;
  logic take;
  cmd_t cls;

  assign in_full   = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign accept    = in_push && !in_full;
  assign take      = cmd_valid && cmd_ready;

  // drop writes aimed past the table
  assign keep = accept && ((in_item.action == ACT_LOOKUP) ||
                           (32'(in_item.entry_index) < 32'(TABLE_DEPTH)));

  always_comb begin
    cls.kind   = (in_item.action == ACT_LOOKUP) ? CMD_LOOKUP : CMD_WRITE;
    cls.index  = in_item.entry_index;
    cls.prefix = in_item.entry_prefix;
    cls.mask   = in_item.entry_mask;
    cls.port   = in_item.entry_port;
    cls.addr   = in_item.dest_addr;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (keep) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (keep && !take) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (take && !keep) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lprl_back.sv -----
`default_nettype none

module lprl_back
  import lprl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_t       cmd,
  output logic            out_empty,
  input  wire logic       out_pop,
  output out_item_t       out_item
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t       state_r;
  logic [7:0]   cfg_entries_r;
  logic [31:0]  addr_r;
  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] limit_nxt;
  logic [IDX_W-1:0] rd_cnt_r;
  logic         pend_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic         found_r;
  logic [31:0]  best_mask_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [7:0]   best_port_r;
  logic         out_valid_r;
  out_item_t    out_item_r;

  route_entry_t wr_entry;
  route_entry_t rd_entry;
  logic         ram_we;
  logic         hit;
  logic         better;
  logic         out_free;
  logic         out_load;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state_r == ST_IDLE);
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_pop;
  assign out_load  = (state_r == ST_DONE) && out_free;

  assign ram_we          = (state_r == ST_IDLE) && cmd_valid && (cmd.kind == CMD_WRITE);
  assign wr_entry.prefix = cmd.prefix;
  assign wr_entry.mask   = cmd.mask;
  assign wr_entry.port   = cmd.port;

  lprl_ram #(
    .WIDTH ($bits(route_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (IDX_W'(cmd.index)),
    .wdata   (wr_entry),
    .raddr   (rd_cnt_r),
    .rdata_r (rd_entry)
  );

  // clamp the search count to the table
  always_comb begin
    if (32'(cfg_entries_r) > 32'(TABLE_DEPTH)) begin
      limit_nxt = CNT_W'(TABLE_DEPTH);
    end else begin
      limit_nxt = CNT_W'(cfg_entries_r);
    end
  end

  assign hit    = pend_r && ((addr_r & rd_entry.mask) == rd_entry.prefix);
  assign better = hit && (!found_r || (rd_entry.mask > best_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_entries_r <= '0;
      pend_r        <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_entries_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= 1'b0;
      if (better) begin
        found_r     <= 1'b1;
        best_mask_r <= rd_entry.mask;
        best_idx_r  <= pend_idx_r;
        best_port_r <= rd_entry.port;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid && (cmd.kind == CMD_LOOKUP)) begin
            addr_r   <= cmd.addr;
            limit_r  <= limit_nxt;
            rd_cnt_r <= '0;
            found_r  <= 1'b0;
            state_r  <= (limit_nxt == '0) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r     <= 1'b1;
          pend_idx_r <= rd_cnt_r;
          rd_cnt_r   <= rd_cnt_r + 1'b1;
          if (CNT_W'(rd_cnt_r) == limit_r - 1'b1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_item_r.route_found <= found_r;
            out_item_r.out_port    <= found_r ? best_port_r : 8'd0;
            out_item_r.match_slot  <= found_r ? 7'(best_idx_r) : 7'd0;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/longest_prefix_route_lookup_top_test.sv -----
`default_nettype none

module longest_prefix_route_lookup_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lprl_pkg::*;

  localparam int TBL           = DEPTH_DEFAULT;
  localparam int ITEM_GOAL     = 1750;
  localparam int CALM_AFTER    = 1600;   // no idling on either side past this item count
  localparam int HOLDOFF       = 300;    // long receiver stall that backs the block up
  localparam int SETTLE_CYCLES = TBL + 8; // longest scan plus queued table writes
  localparam int STALL_LIMIT   = 2000;   // cycles with no handshake before giving up

  // Route table mirror and the queue of routes still owed by the block.
  class route_checker;
    logic [31:0] prefix_tab[TBL];
    logic [31:0] mask_tab[TBL];
    logic [7:0]  port_tab[TBL];
    logic [7:0]  search_count;
    out_item_t   pending_routes[$];
    int          fail_count;

    function void set_count(input logic [7:0] n);
      search_count = n;
    endfunction

    // Number of slots a lookup scans; a count above the table covers all of it.
    function int span();
      return (int'(search_count) > TBL) ? TBL : int'(search_count);
    endfunction

    // Largest mask value wins; strict compare keeps the lowest slot on a tie.
    function out_item_t predict_route(input logic [31:0] addr);
      out_item_t   r;
      logic [31:0] top_mask;
      r = '0;
      top_mask = '0;
      for (int i = 0; i < span(); i++) begin
        if ((addr & mask_tab[i]) == prefix_tab[i] &&
            (!r.route_found || mask_tab[i] > top_mask)) begin
          r.route_found = 1'b1;
          r.out_port    = port_tab[i];
          r.match_slot  = 7'(i);
          top_mask      = mask_tab[i];
        end
      end
      return r;
    endfunction

    function void note_item(input in_item_t item);
      if (item.action == ACT_WRITE) begin
        if (int'(item.entry_index) < TBL) begin
          prefix_tab[item.entry_index] = item.entry_prefix;
          mask_tab[item.entry_index]   = item.entry_mask;
          port_tab[item.entry_index]   = item.entry_port;
        end
      end else begin
        pending_routes.push_back(predict_route(item.dest_addr));
      end
    endfunction

    function void check_route(input out_item_t got);
      out_item_t want;
      if (pending_routes.size() == 0) begin
        $display("%0t: unexpected route result found=%0b port=%0d slot=%0d",
                 $time, got.route_found, got.out_port, got.match_slot);
        fail_count++;
        return;
      end
      want = pending_routes.pop_front();
      if (got.route_found !== want.route_found) begin
        $display("%0t: route_found expected %0b, got %0b",
                 $time, want.route_found, got.route_found);
        fail_count++;
      end
      if (got.out_port !== want.out_port) begin
        $display("%0t: out_port expected %0d, got %0d", $time, want.out_port, got.out_port);
        fail_count++;
      end
      if (got.match_slot !== want.match_slot) begin
        $display("%0t: match_slot expected %0d, got %0d",
                 $time, want.match_slot, got.match_slot);
        fail_count++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_push   = 1'b0;
  logic       in_full;
  in_item_t   in_item   = '0;
  logic       out_empty;
  logic       out_pop   = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  route_checker routes = new();

  int          items_sent     = 0;
  int          send_gap_odds  = 0;   // 0 means the sender never idles
  bit          calm           = 1'b0;
  bit          holdoff_wanted = 1'b0;
  logic [31:0] net_pool[4];          // shared network bases so prefixes nest and tie

  longest_prefix_route_lookup_top #(.TABLE_DEPTH(TBL)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic in_item_t make_write(input logic [6:0] slot, input logic [31:0] prefix,
                                          input logic [31:0] mask, input logic [7:0] port);
    in_item_t item;
    item.action       = ACT_WRITE;
    item.entry_index  = slot;
    item.entry_prefix = prefix;
    item.entry_mask   = mask;
    item.entry_port   = port;
    item.dest_addr    = $urandom;   // ignored on a write
    return item;
  endfunction

  function automatic in_item_t make_lookup(input logic [31:0] addr);
    in_item_t item;
    item.action       = ACT_LOOKUP;
    item.entry_index  = 7'($urandom);   // write fields are ignored on a lookup
    item.entry_prefix = $urandom;
    item.entry_mask   = $urandom;
    item.entry_port   = 8'($urandom);
    item.dest_addr    = addr;
    return item;
  endfunction

  // Mostly contiguous masks over a few shared bases; now and then a raw random
  // mask and prefix, which may hold bits outside the mask and never match.
  function automatic in_item_t random_entry(input logic [6:0] slot);
    logic [31:0] mask;
    logic [31:0] prefix;
    logic [31:0] base;
    int          len;
    len    = $urandom_range(0, 32);
    mask   = 32'hFFFF_FFFF << (32 - len);
    base   = ($urandom_range(0, 7) == 0) ? $urandom : net_pool[$urandom_range(0, 3)];
    prefix = base & mask;
    if ($urandom_range(0, 9) == 0) begin
      mask   = $urandom;
      prefix = $urandom;
    end
    return make_write(slot, prefix, mask, 8'($urandom));
  endfunction

  // Aim most addresses at a searched entry so matches and nested prefixes show up.
  function automatic in_item_t random_lookup();
    int          n;
    int          k;
    logic [31:0] addr;
    n    = routes.span();
    addr = $urandom;
    if (n > 0 && $urandom_range(0, 3) != 0) begin
      k    = $urandom_range(0, n - 1);
      addr = (routes.prefix_tab[k] & routes.mask_tab[k]) | (addr & ~routes.mask_tab[k]);
    end
    return make_lookup(addr);
  endfunction

  // Offer one item, optionally after an idle burst; hold push high on return so
  // back-to-back items keep it up without a drop in between.
  task automatic push_item(input in_item_t item);
    if (!calm && send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_item <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    routes.note_item(item);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Drop push, wait for every owed route, then let trailing table writes finish.
  task automatic settle();
    in_push <= 1'b0;
    while (routes.pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entries(input logic [7:0] n);
    settle();
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    routes.set_count(n);
  endtask

  // Result side: check each popped route, then pick the next pop with random
  // stall bursts whose odds are redrawn at random from three settings.
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    int  cyc;
    int  odds;
    bit  holdoff_started;
    stall_left      = 0;
    hold_left       = 0;
    cyc             = 0;
    odds            = 0;
    holdoff_started = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) routes.check_route(out_item);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 3;
          default: odds = 12;
        endcase
      end
      if (holdoff_wanted && !holdoff_started) begin
        holdoff_started = 1'b1;
        hold_left       = HOLDOFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!calm && odds != 0 && $urandom_range(1, odds) == 1) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Abort when no handshake of any kind completes for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int         phase;
    int         burst;
    int         n;
    logic [6:0] slot;
    logic [7:0] count;

    foreach (net_pool[i]) net_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: the register resets to zero, so nothing is searched yet.
    push_item(make_lookup(32'h0000_0000));
    push_item(make_lookup(32'hFFFF_FFFF));

    // Default route, nested /8 and /16, a /16 tie, a host route, a sparse mask,
    // a prefix with bits outside its mask, and the top slot.
    push_item(make_write(7'd0, 32'h0000_0000, 32'h0000_0000, 8'h11));
    push_item(make_write(7'd1, 32'h0A00_0000, 32'hFF00_0000, 8'h22));
    push_item(make_write(7'd2, 32'h0A01_0000, 32'hFFFF_0000, 8'hFF));
    push_item(make_write(7'd3, 32'h0A01_0000, 32'hFFFF_0000, 8'h44));
    push_item(make_write(7'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00));
    push_item(make_write(7'd5, 32'h0000_00FF, 32'h0000_00FF, 8'h55));
    push_item(make_write(7'd6, 32'hC0A8_0001, 32'hFFFF_0000, 8'h66));
    push_item(make_write(7'd127, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 8'h7F));

    set_entries(8'd7);
    push_item(make_lookup(32'h0A01_0203));   // /16 tie, lower slot wins
    push_item(make_lookup(32'h0A02_0000));   // /8 only
    push_item(make_lookup(32'h0B00_0000));   // default route
    push_item(make_lookup(32'hFFFF_FFFF));   // host route beats sparse mask
    push_item(make_lookup(32'h1234_00FF));   // sparse mask beats default
    push_item(make_lookup(32'hC0A8_0001));   // unmatchable entry skipped
    push_item(make_lookup(32'h0000_0000));

    set_entries(8'd2);
    push_item(make_lookup(32'h0A01_0203));   // /16 entries now out of range

    // Load every slot so any count, up to the full 8-bit range, is legal.
    for (int i = 0; i < TBL; i++) push_item(random_entry(7'(i)));

    // Random phases: each picks a count, an idle rate and a mix of items.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase)
        0:       count = 8'd3;
        1:       count = 8'd0;
        2:       count = 8'd1;
        3:       count = 8'(TBL);
        4:       count = 8'hFF;
        5:       count = 8'(TBL + 1);
        default: begin
          case ($urandom_range(0, 9))
            0:       count = 8'($urandom_range(TBL, 255));
            1:       count = 8'd0;
            default: count = 8'($urandom_range(1, 16));
          endcase
        end
      endcase
      set_entries(count);
      // First phase: stall the receiver long enough to back the block up.
      if (phase == 0) holdoff_wanted = 1'b1;
      case ($urandom_range(0, 2))
        0:       send_gap_odds = 0;
        1:       send_gap_odds = 3;
        default: send_gap_odds = 10;
      endcase
      burst = (phase == 0) ? 60 : $urandom_range(15, 50);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 6) begin
          push_item(random_lookup());
        end else begin
          n    = routes.span();
          slot = (n > 0 && $urandom_range(0, 9) < 7) ? 7'($urandom_range(0, n - 1))
                                                    : 7'($urandom_range(0, TBL - 1));
          push_item(random_entry(slot));
        end
      end
      phase++;
    end

    settle();
    if (routes.fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/lprl_pkg.sv
hdl/lprl_ram.sv
hdl/lprl_front.sv
hdl/lprl_back.sv
hdl/longest_prefix_route_lookup_top.sv
test/longest_prefix_route_lookup_top_test.sv
